// File: rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SPF_CHECK_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define SPF_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/spf_pkg.sv
// constants, types and sequencer states of the sieve prime factoriser
package spf_pkg;

    localparam int VALUE_BOUND = 65536;
    localparam int PLIST_DEPTH = 8192;
    localparam int MAX_OUT     = 6;

    localparam int NUM_W  = 16;
    localparam int EXP_W  = 4;
    localparam int VAL_W  = $clog2(VALUE_BOUND);
    localparam int PIDX_W = $clog2(PLIST_DEPTH);
    localparam int PCNT_W = $clog2(PLIST_DEPTH + 1);
    localparam int DCNT_W = $clog2(VAL_W);
    localparam int PAIR_W = $clog2(MAX_OUT);

    typedef logic [NUM_W-1:0] t_num;
    typedef logic [EXP_W-1:0] t_exp;
    typedef logic [VAL_W-1:0] t_val;

    typedef enum logic [11:0] {
        S_CLR  = 12'b0000_0000_0001,
        S_SRD  = 12'b0000_0000_0010,
        S_SCHK = 12'b0000_0000_0100,
        S_PRD  = 12'b0000_0000_1000,
        S_PMUL = 12'b0000_0001_0000,
        S_PWR  = 12'b0000_0010_0000,
        S_IDLE = 12'b0000_0100_0000,
        S_FRD  = 12'b0000_1000_0000,
        S_FGET = 12'b0001_0000_0000,
        S_DIV  = 12'b0010_0000_0000,
        S_DEC  = 12'b0100_0000_0000,
        S_EMIT = 12'b1000_0000_0000
    } t_state;

endpackage

// File: rtl/spf_sieve_prime_factorizer.sv
// top level: linear-sieve smallest-prime-factor table and iterative factoriser
//
//  channel   direction  handshake             payload
//  input     in         i_valid / o_stall     i_number
//  output    out        o_valid / i_stall     o_prime_factor, o_exponent, o_last_pair
//
// after reset the table is cleared (one entry a cycle) and then filled by the linear
// sieve; o_stall stays high throughout
// per number: a table read, a unit load and a transfer per distinct prime, plus the
// trial divisions in the shared restoring divider (one quotient bit a cycle); that
// divider sets the rate, and no new number is taken until the last pair is loaded
// 0, 1 and out-of-range numbers are taken and give nothing
// the output register lets the next number be taken while the last pair still waits
module spf_sieve_prime_factorizer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  spf_pkg::t_num i_number,
    output logic          o_valid,
    input  logic          i_stall,
    output spf_pkg::t_num o_prime_factor,
    output spf_pkg::t_exp o_exponent,
    output logic          o_last_pair
);
    import spf_pkg::*;

    localparam logic [2*VAL_W-1:0] PROD_BOUND = (2*VAL_W)'(VALUE_BOUND);
    localparam t_val V_LAST = VAL_W'(VALUE_BOUND - 1);

    // smallest prime factor table and the prime list
    t_val spf_mem [VALUE_BOUND];
    t_val pl_mem  [PLIST_DEPTH];

    t_state              r_state, n_state;
    t_val                r_v, n_v;          // sieve value, also the clear address
    logic [PIDX_W-1:0]   r_k, n_k;          // prime list index
    logic [PCNT_W-1:0]   r_pcnt, n_pcnt;    // primes stored
    t_val                r_spfv, n_spfv;    // smallest factor of the sieve value
    logic [2*VAL_W-1:0]  r_prod, n_prod;    // multiple to be marked
    t_val                r_p, n_p;          // current prime (sieve and divisor)
    t_val                r_rest, n_rest;    // what is left of the number
    t_val                r_rem, n_rem;      // divider partial remainder
    t_val                r_quo, n_quo;      // divider dividend / quotient shifter
    logic [DCNT_W-1:0]   r_dcnt, n_dcnt;
    t_exp                r_mult, n_mult;
    logic [PAIR_W-1:0]   r_pairs, n_pairs;
    logic                r_last, n_last;

    logic                r_out_valid;
    t_num                r_out_p;
    t_exp                r_out_e;
    logic                r_out_last;

    t_val                r_spf_q;
    t_val                r_pl_q;

    logic                spf_we;
    t_val                spf_wa, spf_wd, spf_ra;
    logic                pl_we;
    logic [PIDX_W-1:0]   pl_wa, pl_ra;
    t_val                pl_wd;
    logic                out_load;
    logic                in_ok;

    // shared restoring divider step
    logic [VAL_W:0]      trial, diff;
    logic                q_bit;

    assign trial = {r_rem, r_quo[VAL_W-1]};
    assign diff  = trial - {1'b0, r_p};
    assign q_bit = !diff[VAL_W];

    assign in_ok = (i_number >= NUM_W'(2)) && (32'(i_number) < 32'(VALUE_BOUND));

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_prime_factor = r_out_p;
    assign o_exponent     = r_out_e;
    assign o_last_pair    = r_out_last;

    always_comb begin
        n_state  = r_state;
        n_v      = r_v;
        n_k      = r_k;
        n_pcnt   = r_pcnt;
        n_spfv   = r_spfv;
        n_prod   = r_prod;
        n_p      = r_p;
        n_rest   = r_rest;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_dcnt   = r_dcnt;
        n_mult   = r_mult;
        n_pairs  = r_pairs;
        n_last   = r_last;
        spf_we   = 1'b0;
        spf_wa   = r_v;
        spf_wd   = '0;
        spf_ra   = r_v;
        pl_we    = 1'b0;
        pl_wa    = r_pcnt[PIDX_W-1:0];
        pl_wd    = r_v;
        pl_ra    = r_k;
        out_load = 1'b0;

        case (r_state)
            S_CLR: begin
                spf_we = 1'b1;
                if (r_v == V_LAST) begin
                    n_v     = VAL_W'(2);
                    n_state = S_SRD;
                end else begin
                    n_v = r_v + VAL_W'(1);
                end
            end
            S_SRD: begin
                n_state = S_SCHK;
            end
            S_SCHK: begin
                // an untouched entry is a prime
                n_k = '0;
                if (r_spf_q == '0) begin
                    spf_we = 1'b1;
                    spf_wd = r_v;
                    n_spfv = r_v;
                    if (r_pcnt < PCNT_W'(PLIST_DEPTH)) begin
                        pl_we  = 1'b1;
                        n_pcnt = r_pcnt + PCNT_W'(1);
                    end
                end else begin
                    n_spfv = r_spf_q;
                end
                n_state = S_PRD;
            end
            S_PRD: begin
                n_state = S_PMUL;
            end
            S_PMUL: begin
                n_p     = r_pl_q;
                n_prod  = (2*VAL_W)'(r_v) * (2*VAL_W)'(r_pl_q);
                n_state = S_PWR;
            end
            S_PWR: begin
                if (r_p > r_spfv || r_prod >= PROD_BOUND ||
                    (PCNT_W'(r_k) + PCNT_W'(1) >= r_pcnt)) begin
                    if (!(r_p > r_spfv || r_prod >= PROD_BOUND)) begin
                        spf_we = 1'b1;
                        spf_wa = r_prod[VAL_W-1:0];
                        spf_wd = r_p;
                    end
                    if (r_v == V_LAST) begin
                        n_state = S_IDLE;
                    end else begin
                        n_v     = r_v + VAL_W'(1);
                        n_state = S_SRD;
                    end
                end else begin
                    spf_we  = 1'b1;
                    spf_wa  = r_prod[VAL_W-1:0];
                    spf_wd  = r_p;
                    n_k     = r_k + PIDX_W'(1);
                    n_state = S_PRD;
                end
            end
            S_IDLE: begin
                if (i_valid && in_ok) begin
                    n_rest  = VAL_W'(i_number);
                    n_mult  = '0;
                    n_pairs = '0;
                    n_state = S_FRD;
                end
            end
            S_FRD: begin
                spf_ra  = r_rest;
                n_state = S_FGET;
            end
            S_FGET: begin
                n_p     = r_spf_q;
                n_rem   = '0;
                n_quo   = r_rest;
                n_dcnt  = DCNT_W'(VAL_W - 1);
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem = q_bit ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
                n_quo = {r_quo[VAL_W-2:0], q_bit};
                if (r_dcnt == '0) begin
                    n_state = S_DEC;
                end else begin
                    n_dcnt = r_dcnt - DCNT_W'(1);
                end
            end
            S_DEC: begin
                if (r_rem == '0) begin
                    n_mult = r_mult + EXP_W'(1);
                    n_rest = r_quo;
                    if (r_quo == VAL_W'(1)) begin
                        n_last  = 1'b1;
                        n_state = S_EMIT;
                    end else begin
                        // divide again, the quotient is already the dividend
                        n_rem   = '0;
                        n_dcnt  = DCNT_W'(VAL_W - 1);
                        n_state = S_DIV;
                    end
                end else begin
                    n_last  = (r_pairs == PAIR_W'(MAX_OUT - 1));
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || !i_stall) begin
                    out_load = 1'b1;
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_pairs = r_pairs + PAIR_W'(1);
                        n_mult  = '0;
                        n_state = S_FRD;
                    end
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_v         <= '0;
            r_pcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_v         <= n_v;
            r_pcnt      <= n_pcnt;
            r_out_valid <= out_load || (r_out_valid && i_stall);
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_k     <= n_k;
        r_spfv  <= n_spfv;
        r_prod  <= n_prod;
        r_p     <= n_p;
        r_rest  <= n_rest;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_dcnt  <= n_dcnt;
        r_mult  <= n_mult;
        r_pairs <= n_pairs;
        r_last  <= n_last;
        if (out_load) begin
            r_out_p    <= NUM_W'(r_p);
            r_out_e    <= r_mult;
            r_out_last <= r_last;
        end
    end

    // table memory: one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (spf_we) begin
            spf_mem[spf_wa] <= spf_wd;
        end
        r_spf_q <= spf_mem[spf_ra];
    end

    // prime list memory
    always_ff @(posedge i_clk) begin
        if (pl_we) begin
            pl_mem[pl_wa] <= pl_wd;
        end
        r_pl_q <= pl_mem[pl_ra];
    end

`include "assert_macros.svh"

    `SPF_CHECK_IMP(a_spf_sane, r_state == S_FGET, r_spf_q >= VAL_W'(2) && r_spf_q <= r_rest, "table lookup gave no factor of the rest")
    `SPF_CHECK_IMP(a_prime_small, r_state == S_PMUL, r_pl_q <= r_v, "listed prime above the sieve value")
    `SPF_CHECK_IMP(a_pair_ok, o_valid, o_exponent != '0 && o_prime_factor >= NUM_W'(2), "bad pair in output register")
    `SPF_CHECK_NEXT(a_fresh_item, i_valid && !o_stall && in_ok, r_mult == '0 && r_pairs == '0, "counters not cleared for new number")

endmodule

// File: sim/spf_factor_checker.sv
// pair checker for the sieve factoriser: own smallest-prime-factor table and pair scoreboard
module spf_factor_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_num_valid,
    input  logic          i_num_stall,
    input  spf_pkg::t_num i_number,
    input  logic          i_pair_valid,
    input  logic          i_pair_stall,
    input  spf_pkg::t_num i_prime_factor,
    input  spf_pkg::t_exp i_exponent,
    input  logic          i_last_pair,
    output int            o_fail_count,
    output int            o_pairs_pending
);
    import spf_pkg::*;

    typedef struct packed {
        t_num source;
        t_num prime_factor;
        t_exp exponent;
        logic last_pair;
    } t_pair;

    int unsigned spf_of [VALUE_BOUND];
    int unsigned primes_kept [PLIST_DEPTH];
    int unsigned primes_stored;
    bit          table_ready;
    t_pair       pairs_due [$];
    int          fail_tally;

    assign o_fail_count = fail_tally;

    // linear sieve, same fill order as the block, primes past the list size are not kept
    initial begin : fill_spf_table
        int unsigned     v;
        int unsigned     k;
        int unsigned     p;
        longint unsigned prod;
        primes_stored = 0;
        for (v = 0; v < VALUE_BOUND; v++)
            spf_of[v] = 0;
        for (v = 2; v < VALUE_BOUND; v++) begin
            if (spf_of[v] == 0) begin
                spf_of[v] = v;
                if (primes_stored < PLIST_DEPTH) begin
                    primes_kept[primes_stored] = v;
                    primes_stored++;
                end
            end
            for (k = 0; k < primes_stored; k++) begin
                p    = primes_kept[k];
                prod = longint'(v) * p;
                if (p > spf_of[v] || prod >= VALUE_BOUND)
                    break;
                spf_of[prod] = p;
            end
        end
        table_ready = 1'b1;
    end

    function automatic void predict_pairs(input t_num value);
        t_pair       found [MAX_OUT];
        int unsigned rest;
        int unsigned p;
        int unsigned mult;
        int          cnt;
        rest = value;
        cnt  = 0;
        if (!table_ready || rest < 2 || rest >= VALUE_BOUND)
            return;
        while (rest > 1 && cnt < MAX_OUT) begin
            p = spf_of[rest];
            if (p < 2)
                break;
            mult = 0;
            while (rest % p == 0) begin
                rest = rest / p;
                mult++;
            end
            found[cnt] = '{source: value, prime_factor: t_num'(p),
                           exponent: t_exp'(mult), last_pair: 1'b0};
            cnt++;
        end
        for (int i = 0; i < cnt; i++) begin
            found[i].last_pair = (i == cnt - 1);
            pairs_due.push_back(found[i]);
        end
    endfunction

    task automatic note_failure(input string what);
        fail_tally++;
        if (fail_tally <= 10)
            $display("%s", what);
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_pair due;
        if (i_rst_n) begin
            if (i_num_valid && !i_num_stall)
                predict_pairs(i_number);
            if (i_pair_valid && !i_pair_stall) begin
                if (pairs_due.size() == 0) begin
                    note_failure($sformatf("unexpected pair: prime %0d exponent %0d last %0b",
                                           i_prime_factor, i_exponent, i_last_pair));
                end else begin
                    due = pairs_due.pop_front();
                    if (due.prime_factor !== i_prime_factor || due.exponent !== i_exponent ||
                        due.last_pair !== i_last_pair)
                        note_failure($sformatf({"pair mismatch for %0d: expected prime %0d ",
                                                "exponent %0d last %0b, got prime %0d ",
                                                "exponent %0d last %0b"},
                                               due.source, due.prime_factor, due.exponent,
                                               due.last_pair, i_prime_factor, i_exponent,
                                               i_last_pair));
                end
            end
        end
        o_pairs_pending <= pairs_due.size();
    end

endmodule

// File: sim/spf_sieve_prime_factorizer_test.sv
// testbench top for the sieve factoriser: stimulus, handshake idling and final verdict
module spf_sieve_prime_factorizer_test;
    import spf_pkg::*;

    // longest quiet stretch in a good run is the table clear plus sieve after reset,
    // so the watchdog limit must lie above it
    localparam int IDLE_LIMIT  = 2_000_000;
    localparam int TAIL_CYCLES = 400;
    localparam int ITEM_COUNT  = 76;

    logic clk        = 1'b0;
    logic rst_n      = 1'b0;
    logic num_valid  = 1'b0;
    logic num_stall;
    t_num number     = '0;
    logic pair_valid;
    logic pair_stall = 1'b0;
    t_num prime_factor;
    t_exp exponent;
    logic last_pair;
    int   fail_count;
    int   pairs_pending;
    int   idle_cycles = 0;

    // edges of the range, prime powers, six distinct primes, the largest prime,
    // and the zero/one numbers that give no pair
    t_num corner_numbers [24] = '{
        16'd0,     16'd1,     16'd2,     16'd3,     16'd4,     16'd65535,
        16'd65534, 16'd65521, 16'd32768, 16'd30030, 16'd60060, 16'd59049,
        16'd64507, 16'd65025, 16'd49152, 16'd46189, 16'd1,     16'd0,
        16'd6,     16'd43690, 16'd21845, 16'd65533, 16'd7,     16'd65280
    };
    int unsigned small_primes [8] = '{2, 3, 5, 7, 11, 13, 17, 19};

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    spf_sieve_prime_factorizer uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (num_valid),
        .o_stall        (num_stall),
        .i_number       (number),
        .o_valid        (pair_valid),
        .i_stall        (pair_stall),
        .o_prime_factor (prime_factor),
        .o_exponent     (exponent),
        .o_last_pair    (last_pair)
    );

    spf_factor_checker pair_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_num_valid     (num_valid),
        .i_num_stall     (num_stall),
        .i_number        (number),
        .i_pair_valid    (pair_valid),
        .i_pair_stall    (pair_stall),
        .i_prime_factor  (prime_factor),
        .i_exponent      (exponent),
        .i_last_pair     (last_pair),
        .o_fail_count    (fail_count),
        .o_pairs_pending (pairs_pending)
    );

    // offer one number after an optional gap and hold it until the transfer;
    // valid is only lowered during a gap, so back-to-back numbers keep it high
    task automatic send_number(input t_num value, input int gap);
        if (gap > 0) begin
            num_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        num_valid <= 1'b1;
        number    <= value;
        @(posedge clk);
        while (num_stall !== 1'b0) @(posedge clk);
    endtask

    // stop offering and wait until the checker holds no outstanding pair;
    // the pending count is registered, hence the do-while form
    task automatic wait_for_drain();
        num_valid <= 1'b0;
        do @(posedge clk); while (pairs_pending != 0);
    endtask

    // watchdog: any transfer on either side restarts the count
    always @(posedge clk) begin
        if ((num_valid && num_stall === 1'b0) || (pair_valid === 1'b1 && !pair_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("spf_sieve_prime_factorizer_test: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiving side: a fresh hold-off before every pair, with calm stretches
    initial begin : pair_sink
        int hold;
        int served;
        bit calm;
        served = 0;
        calm   = 1'b0;
        forever begin
            if (served % 12 == 0)
                calm = ($urandom_range(0, 3) == 0);
            hold = calm ? 0 : $urandom_range(0, 17);
            if (hold > 0) begin
                pair_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                pair_stall <= 1'b0;
            end
            @(posedge clk);
            while (pair_valid !== 1'b1) @(posedge clk);
            served++;
        end
    end

    // sending side: reset, corner numbers, then random numbers
    initial begin : number_source
        int          k;
        int unsigned v;
        int unsigned p;
        bit          calm;
        calm = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // first number waits out the sieve fill behind the stall
        for (k = 0; k < 24; k++)
            send_number(corner_numbers[k], $urandom_range(0, 17));
        wait_for_drain();

        for (k = 0; k < ITEM_COUNT; k++) begin
            // pause once with the pipeline empty so the block sees a cold start
            if (k == ITEM_COUNT / 2)
                wait_for_drain();
            if (k % 16 == 0)
                calm = ($urandom_range(0, 2) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: v = $urandom_range(0, 65535);
                5: v = $urandom_range(0, 40);
                6, 7, 8: begin
                    // smooth number, a product of small primes, often several distinct
                    v = 1;
                    repeat ($urandom_range(1, 14)) begin
                        p = small_primes[$urandom_range(0, 7)];
                        if (v * p < VALUE_BOUND)
                            v = v * p;
                    end
                end
                default: begin
                    // power of one small prime, high exponents
                    p = small_primes[$urandom_range(0, 7)];
                    v = p;
                    while (v * p < VALUE_BOUND && $urandom_range(0, 4) != 0)
                        v = v * p;
                end
            endcase
            send_number(t_num'(v), calm ? 0 : $urandom_range(0, 17));
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pairs_pending == 0)
            $display("spf_sieve_prime_factorizer_test: done, clean");
        else
            $display("spf_sieve_prime_factorizer_test: done, errors");
        $finish;
    end

endmodule
